// ===== hdl/khtcm_pkg.sv =====
// Shared constants, command struct and palette lookup for the key heat tracker.
// Used by khtcm_ctrl, khtcm_datapath and key_heat_tracker_color_map.
// No dependencies.
package khtcm_pkg;

   // Table geometry
   localparam int KEYS      = 128;
   localparam int ADDR_W    = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int KEY_W     = 7;
   localparam int KEY_EXT_W = ((ADDR_W > KEY_W) ? ADDR_W : KEY_W) + 1;

   // Field widths
   localparam int HEAT_W  = 16;
   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 24;
   localparam int CSR_W   = 24;
   localparam int CSRI_W  = 2;
   localparam int OP_W    = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_PRESS = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Register indexes
   localparam logic [CSRI_W-1:0] CSR_GAIN  = 2'd0;
   localparam logic [CSRI_W-1:0] CSR_DECAY = 2'd1;
   localparam logic [CSRI_W-1:0] CSR_COLD  = 2'd2;

   // Register reset values
   localparam logic [HEAT_W-1:0]  GAIN_RESET  = 16'd6554;
   localparam logic [HEAT_W-1:0]  DECAY_RESET = 16'd63000;
   localparam logic [COLOR_W-1:0] COLD_RESET  = 24'd40;

   // Color map constants
   localparam logic [HEAT_W-1:0] COLD_LIMIT = 16'd65;
   localparam logic [2:0]        PAL_LAST   = 3'd5;

   // Controller to datapath commands
   typedef struct packed {
      logic              latch;     // capture key of accepted beat
      logic              sel_cnt;   // table address from sweep counter
      logic [ADDR_W-1:0] cnt;       // sweep counter
      logic              tick_mul;  // register heat * decay
      logic              wr_tick;   // write decayed heat
      logic              wr_press;  // write saturated press sum
      logic              pos_load;  // register palette position
      logic              mix_load;  // register blended or cold color, strobe result
   } cmd_type;

   // Default palette, red in the high byte
   function automatic logic [COLOR_W-1:0] palette_color(input logic [2:0] idx);
      logic [COLOR_W-1:0] c;
      case (idx)
         3'd0:    c = {8'd0,   8'd0,   8'd40};
         3'd1:    c = {8'd0,   8'd90,  8'd200};
         3'd2:    c = {8'd0,   8'd220, 8'd200};
         3'd3:    c = {8'd220, 8'd220, 8'd40};
         3'd4:    c = {8'd255, 8'd90,  8'd20};
         default: c = {8'd255, 8'd255, 8'd255};
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/key_heat_tracker_color_map.sv =====
// Top level of the key heat tracker with color map.
// Depends on khtcm_pkg, khtcm_ctrl and khtcm_datapath.
//
//   channel   ports                                   handshake
//   request   req_op, req_key                         start high, busy low
//   result    rsp_red, rsp_green, rsp_blue            rsp_valid, one cycle
//   config    csr_index, csr_wdata                    csr_we
//
// A read beat passes S_READ_RD, S_READ_POS and S_READ_MIX, and the result register
// then raises the color strobe. A press reads, then writes its key. A tick does
// one read, one multiply and one write per key through the single table port.
// Reset is synchronous and active high; it clears the heat table through per-key
// valid bits and restores register defaults, with no clearing pass.
// The result strobe cannot be stalled; start is taken only while busy is low.
module key_heat_tracker_color_map (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [khtcm_pkg::OP_W-1:0]      req_op,
   input  logic [khtcm_pkg::KEY_W-1:0]     req_key,
   output logic                            rsp_valid,
   output logic [khtcm_pkg::CHAN_W-1:0]    rsp_red,
   output logic [khtcm_pkg::CHAN_W-1:0]    rsp_green,
   output logic [khtcm_pkg::CHAN_W-1:0]    rsp_blue,
   input  logic                            csr_we,
   input  logic [khtcm_pkg::CSRI_W-1:0]    csr_index,
   input  logic [khtcm_pkg::CSR_W-1:0]     csr_wdata
);

   khtcm_pkg::cmd_type cmd;

   khtcm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .busy   (busy),
      .cmd    (cmd)
   );

   khtcm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_key   (req_key),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

   // A result beat is a single-cycle strobe
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // The block is idle again when the result beat is shown
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // An accepted read produces its beat at a fixed latency
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == khtcm_pkg::OP_READ)) |-> ##4 rsp_valid)
      else $error("read beat missing its result");

   // Ticks and presses never produce a result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op != khtcm_pkg::OP_READ)) |-> ##4 !rsp_valid)
      else $error("result produced for a non-read beat");

endmodule

// ===== hdl/khtcm_ctrl.sv =====
// Sequencer for the key heat tracker: decodes accepted beats and steps the datapath.
// Depends on khtcm_pkg.
module khtcm_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [khtcm_pkg::OP_W-1:0]   req_op,
   output logic                         busy,
   output khtcm_pkg::cmd_type           cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_TICK_RD,
      S_TICK_MUL,
      S_TICK_WR,
      S_PRESS_RD,
      S_PRESS_WR,
      S_READ_RD,
      S_READ_POS,
      S_READ_MIX
   } state_type;

   state_type                       state_ff;
   logic [khtcm_pkg::ADDR_W-1:0]    cnt_ff;
   logic                            accept;
   logic                            last_key;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign last_key = (cnt_ff == khtcm_pkg::ADDR_W'(khtcm_pkg::KEYS - 1));

   // State and sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (accept) begin
                  if (req_op == khtcm_pkg::OP_TICK) begin
                     state_ff <= S_TICK_RD;
                  end else if (req_op == khtcm_pkg::OP_PRESS) begin
                     state_ff <= S_PRESS_RD;
                  end else if (req_op == khtcm_pkg::OP_READ) begin
                     state_ff <= S_READ_RD;
                  end
               end
            end
            S_TICK_RD:  state_ff <= S_TICK_MUL;
            S_TICK_MUL: state_ff <= S_TICK_WR;
            S_TICK_WR: begin
               if (last_key) begin
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_TICK_RD;
               end
            end
            S_PRESS_RD: state_ff <= S_PRESS_WR;
            S_PRESS_WR: state_ff <= S_IDLE;
            S_READ_RD:  state_ff <= S_READ_POS;
            S_READ_POS: state_ff <= S_READ_MIX;
            S_READ_MIX: state_ff <= S_IDLE;
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

   // Command decode
   always_comb begin
      cmd          = '0;
      cmd.latch    = accept;
      cmd.cnt      = cnt_ff;
      cmd.sel_cnt  = (state_ff == S_TICK_RD) || (state_ff == S_TICK_MUL) ||
                     (state_ff == S_TICK_WR);
      cmd.tick_mul = (state_ff == S_TICK_MUL);
      cmd.wr_tick  = (state_ff == S_TICK_WR);
      cmd.wr_press = (state_ff == S_PRESS_WR);
      cmd.pos_load = (state_ff == S_READ_POS);
      cmd.mix_load = (state_ff == S_READ_MIX);
   end

endmodule

// ===== hdl/khtcm_datapath.sv =====
// Datapath for the key heat tracker: config registers, heat memory, decay,
// press saturation and palette blend. Depends on khtcm_pkg.
module khtcm_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  khtcm_pkg::cmd_type              cmd,
   input  logic [khtcm_pkg::KEY_W-1:0]     req_key,
   input  logic                            csr_we,
   input  logic [khtcm_pkg::CSRI_W-1:0]    csr_index,
   input  logic [khtcm_pkg::CSR_W-1:0]     csr_wdata,
   output logic                            rsp_valid,
   output logic [khtcm_pkg::CHAN_W-1:0]    rsp_red,
   output logic [khtcm_pkg::CHAN_W-1:0]    rsp_green,
   output logic [khtcm_pkg::CHAN_W-1:0]    rsp_blue
);

   localparam int AW = khtcm_pkg::ADDR_W;
   localparam int HW = khtcm_pkg::HEAT_W;
   localparam int CW = khtcm_pkg::CHAN_W;

   // Config registers
   logic [HW-1:0]                       gain_ff;
   logic [HW-1:0]                       decay_ff;
   logic [khtcm_pkg::COLOR_W-1:0]       cold_ff;

   // Heat memory and valid bits
   logic [HW-1:0]                       heat_mem [khtcm_pkg::KEYS];
   logic [khtcm_pkg::KEYS-1:0]          valid_ff;
   logic [HW-1:0]                       rd_data_ff;
   logic                                rd_valid_ff;

   logic [khtcm_pkg::KEY_EXT_W-1:0]     key_ext;
   logic [AW-1:0]                       key_ff;
   logic                                in_range_ff;
   logic [AW-1:0]                       addr;
   logic [HW-1:0]                       heat_rd;
   logic [2*HW-1:0]                     prod_ff;
   logic [HW:0]                         press_sum;
   logic [HW-1:0]                       press_sat;
   logic                                wr_en;
   logic [HW-1:0]                       wr_data;

   // Palette position
   logic [HW-1:0]                       heat_eff;
   logic [HW+2:0]                       pos;
   logic [2:0]                          lo_ff;
   logic [HW-1:0]                       frac_ff;
   logic                                cold_sel_ff;
   logic [2:0]                          hi;
   logic [khtcm_pkg::COLOR_W-1:0]       pal_lo;
   logic [khtcm_pkg::COLOR_W-1:0]       pal_hi;
   logic [khtcm_pkg::COLOR_W-1:0]       mix_color;

   logic                                rsp_valid_ff;
   logic [khtcm_pkg::COLOR_W-1:0]       rsp_color_ff;

   // Config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= khtcm_pkg::GAIN_RESET;
         decay_ff <= khtcm_pkg::DECAY_RESET;
         cold_ff  <= khtcm_pkg::COLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            khtcm_pkg::CSR_GAIN:  gain_ff  <= csr_wdata[HW-1:0];
            khtcm_pkg::CSR_DECAY: decay_ff <= csr_wdata[HW-1:0];
            khtcm_pkg::CSR_COLD:  cold_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Key capture and range check
   assign key_ext = khtcm_pkg::KEY_EXT_W'(req_key);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         key_ff      <= key_ext[AW-1:0];
         in_range_ff <= (key_ext < khtcm_pkg::KEY_EXT_W'(khtcm_pkg::KEYS));
      end
   end

   assign addr = cmd.sel_cnt ? cmd.cnt : key_ff;

   // Write data: decayed heat or saturated press sum
   assign press_sum = {1'b0, heat_rd} + {1'b0, gain_ff};
   assign press_sat = press_sum[HW] ? {HW{1'b1}} : press_sum[HW-1:0];
   assign wr_en     = cmd.wr_tick || (cmd.wr_press && in_range_ff);
   assign wr_data   = cmd.wr_tick ? prod_ff[2*HW-1:HW] : press_sat;

   // Heat memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heat_mem[addr] <= wr_data;
      end
      rd_data_ff <= heat_mem[addr];
   end

   // Valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[addr];
         if (wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
      end
   end

   assign heat_rd = rd_valid_ff ? rd_data_ff : '0;

   // Decay multiply
   always_ff @(posedge clock) begin
      if (cmd.tick_mul) begin
         prod_ff <= heat_rd * decay_ff;
      end
   end

   // Position = heat * 5, integer part picks the palette segment
   assign heat_eff = in_range_ff ? heat_rd : '0;
   assign pos      = {1'b0, heat_eff, 2'b00} + (HW+3)'(heat_eff);

   always_ff @(posedge clock) begin
      if (cmd.pos_load) begin
         lo_ff       <= pos[HW+2:HW];
         frac_ff     <= pos[HW-1:0];
         cold_sel_ff <= (heat_eff <= khtcm_pkg::COLD_LIMIT);
      end
   end

   assign hi     = (lo_ff >= khtcm_pkg::PAL_LAST) ? khtcm_pkg::PAL_LAST : lo_ff + 3'd1;
   assign pal_lo = khtcm_pkg::palette_color(lo_ff);
   assign pal_hi = khtcm_pkg::palette_color(hi);

   // Per-channel blend: a + (b - a) * f, 16 fraction bits
   for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [CW-1:0]        ch_a;
      logic [CW-1:0]        ch_b;
      logic signed [CW:0]   diff;
      logic signed [HW:0]   frac_s;
      logic signed [CW+HW+1:0] term;
      logic signed [CW+HW+1:0] acc;

      assign ch_a   = pal_lo[c*CW +: CW];
      assign ch_b   = pal_hi[c*CW +: CW];
      assign diff   = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
      assign frac_s = $signed({1'b0, frac_ff});
      assign term   = diff * frac_s;
      assign acc    = $signed({2'b00, ch_a, {HW{1'b0}}}) + term;
      assign mix_color[c*CW +: CW] = acc[CW+HW-1:HW];
   end

   // Result register and strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.mix_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mix_load) begin
         rsp_color_ff <= cold_sel_ff ? cold_ff : mix_color;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_color_ff[3*CW-1:2*CW];
   assign rsp_green = rsp_color_ff[2*CW-1:CW];
   assign rsp_blue  = rsp_color_ff[CW-1:0];

endmodule
